>>> hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

>>> hw/rtl/gdv_pkg.sv
package gdv_pkg;
    localparam int unsigned OneQ16 = 65536;
    localparam logic [24:0] DriveMax = 25'h0FFFFFF;

    typedef enum logic [2:0] {
        CfgBandHigh = 3'd0,
        CfgBandLow  = 3'd1,
        CfgNeutral  = 3'd2,
        CfgSatFrac  = 3'd3,
        CfgDeadZone = 3'd4,
        CfgGateTol  = 3'd5,
        CfgDecay    = 3'd6,
        CfgGain     = 3'd7
    } t_cfg_idx;
endpackage

>>> hw/rtl/gated_deadzone_velocity.sv
// One transaction in, one out. A shared 34x34-bit multiplier is reused for each
// product (decay step, divisor, tolerance, drive and smoothstep terms).
// One restoring divider, one quotient bit per cycle, serves the three fractional
// divisions, and each runs its full 16 steps unless its numerator reaches its
// denominator, in which case the quotient is set to one without stepping. A
// magnitude inside the dead zone skips its second division and its smoothstep,
// and a sample that does not pass the gate edge skips the gate division and its
// smoothstep. s_axis_tready is low while an item is in work. The result register
// holds until it is taken, and a result that is still waiting stalls the next
// one. An uncalibrated band goes from the input straight to the output with zero
// outputs. Any configuration write reloads the recent high and low with the
// neutral level.
`include "assert_macros.svh"
module gated_deadzone_velocity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // level[31:0], time_step[51:32], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // drive[24:0], magnitude[41:25], gate[58:42], pad
);
    typedef enum logic [4:0] {
        S_IDLE, S_DS, S_STEP, S_EXT, S_HALF, S_UDEN, S_UDIV, S_MDIV,
        S_SQ, S_CUBE, S_TOL, S_GDIV, S_GSQ, S_GCUBE, S_DR1, S_DR2, S_OUT
    } t_state;

    t_state r_state;
    logic signed [31:0] r_bh, r_bl, r_nl;
    logic [15:0] r_sat, r_dz, r_tol, r_decay, r_gain;
    logic signed [31:0] r_rh, r_rl, r_c;
    logic [19:0] r_dt;
    logic r_up;
    logic signed [33:0] r_half, r_tolv;
    logic [16:0] r_mag, r_gate;
    logic [66:0] r_acc;
    // divider
    logic [49:0] r_rem, r_den;
    logic [16:0] r_q;
    logic [4:0]  r_cnt;
    logic [63:0] r_out;
    t_state      r_dret;

    // shared multiplier
    logic [33:0] mul_a, mul_b;
    logic [67:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [33:0] span, stepv, th, tl, gnum;
    logic [32:0] step_sat;
    logic [16:0] sm_t;
    assign span = 34'(r_bh) - 34'(r_bl);
    // a step of 2^32 or more already moves either extreme onto the sample
    assign step_sat = (r_acc[66:48] != '0) ? 33'h1_0000_0000 : r_acc[48:16];
    assign stepv = 34'(step_sat);
    logic [49:0] rem_sh;
    assign rem_sh = {r_rem[48:0], 1'b0};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        th = 34'(r_rh) - stepv;
        if (34'(r_c) > th) th = 34'(r_c);
        if (th > 34'(r_bh)) th = 34'(r_bh);
        tl = 34'(r_rl) + stepv;
        if (34'(r_c) < tl) tl = 34'(r_c);
        if (tl < 34'(r_bl)) tl = 34'(r_bl);
        gnum = r_up ? 34'(r_c) - (34'(r_rh) - r_tolv) : (34'(r_rl) + r_tolv) - 34'(r_c);
        sm_t = r_q;
        unique case (r_state)
            S_DS:    begin mul_a = 34'(r_decay); mul_b = 34'(r_dt); end
            S_STEP:  begin mul_a = 34'(r_acc[35:8]); mul_b = span; end
            S_UDEN:  begin mul_a = 34'(r_sat); mul_b = r_half; end
            S_SQ, S_GSQ: begin mul_a = 34'(sm_t); mul_b = 34'(sm_t); end
            S_CUBE, S_GCUBE: begin
                mul_a = 34'(r_acc[49:16]);
                mul_b = 34'(3 * gdv_pkg::OneQ16) - 34'({r_q, 1'b0});
            end
            S_TOL:   begin mul_a = 34'(r_tol); mul_b = r_half; end
            S_DR1:   begin mul_a = 34'(r_gain); mul_b = 34'(r_mag); end
            S_DR2:   begin mul_a = 34'(r_acc[32:0]); mul_b = 34'(r_gate); end
            default: ;
        endcase
    end

    logic [40:0] drv;
    logic [24:0] drv_mag, drv_sat;
    assign drv = r_acc[64:24];
    // r_acc is stale when an early exit skips the drive product
    assign drv_mag = (r_mag == '0 || r_gate == '0) ? '0 :
                     (drv > 41'(gdv_pkg::DriveMax)) ? gdv_pkg::DriveMax : drv[24:0];
    assign drv_sat = r_up ? drv_mag : 25'(-drv_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bh <= '0; r_bl <= '0; r_nl <= '0;
            r_sat <= 16'd32768; r_dz <= '0; r_tol <= '0;
            r_decay <= 16'd256; r_gain <= 16'd256;
            r_rh <= '0; r_rl <= '0;
            r_mag <= '0; r_gate <= '0; r_up <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!m_axis_tvalid || m_axis_tready)) m_axis_tvalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            if (i_cfg_we) begin
                unique case (gdv_pkg::t_cfg_idx'(i_cfg_idx))
                    gdv_pkg::CfgBandHigh: r_bh <= i_cfg_data;
                    gdv_pkg::CfgBandLow:  r_bl <= i_cfg_data;
                    gdv_pkg::CfgNeutral:  r_nl <= i_cfg_data;
                    gdv_pkg::CfgSatFrac:  r_sat <= i_cfg_data[15:0];
                    gdv_pkg::CfgDeadZone: r_dz <= i_cfg_data[15:0];
                    gdv_pkg::CfgGateTol:  r_tol <= i_cfg_data[15:0];
                    gdv_pkg::CfgDecay:    r_decay <= i_cfg_data[15:0];
                    gdv_pkg::CfgGain:     r_gain <= i_cfg_data[15:0];
                    default: ;
                endcase
                if (gdv_pkg::t_cfg_idx'(i_cfg_idx) == gdv_pkg::CfgNeutral) begin
                    r_rh <= i_cfg_data; r_rl <= i_cfg_data;
                end else begin
                    r_rh <= r_nl; r_rl <= r_nl;
                end
            end
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_c <= s_axis_tdata[31:0];
                    r_dt <= s_axis_tdata[51:32];
                    r_mag <= '0; r_gate <= '0;
                    r_state <= (span[33] || span == '0) ? S_OUT : S_DS;
                end
                S_DS:   begin r_acc <= 67'(mul_p); r_state <= S_STEP; end
                S_STEP: begin r_acc <= 67'(mul_p); r_state <= S_EXT; end
                S_EXT: begin
                    r_rh <= th[31:0]; r_rl <= tl[31:0];
                    r_up <= (r_c >= r_nl);
                    r_half <= (r_c >= r_nl) ? 34'(r_bh) - 34'(r_nl) : 34'(r_nl) - 34'(r_bl);
                    r_state <= S_HALF;
                end
                S_HALF: r_state <= (r_half[33] || r_half == '0) ? S_OUT : S_UDEN;
                S_UDEN: begin
                    // numerator dist<<16, denominator sat*half
                    r_den <= 50'(mul_p);
                    r_rem <= r_up ? 50'({34'(r_c) - 34'(r_nl), 16'h0})
                                  : 50'({34'(r_nl) - 34'(r_c), 16'h0});
                    r_cnt <= '0; r_q <= '0;
                    r_dret <= S_UDIV;
                    r_state <= S_MDIV;
                end
                S_MDIV: begin
                    if (r_cnt == 5'd0 && r_rem >= r_den) begin
                        r_q <= 17'(gdv_pkg::OneQ16); r_cnt <= 5'd17;
                    end else if (r_cnt == 5'd16 || r_cnt == 5'd17) begin
                        if (r_dret == S_UDIV) begin
                            r_rem <= 50'(r_q) - 50'(r_dz);
                            r_den <= 50'(gdv_pkg::OneQ16) - 50'(r_dz);
                            if (r_q <= 17'(r_dz)) begin
                                r_mag <= '0; r_state <= S_TOL;
                            end else begin
                                r_cnt <= '0; r_q <= '0;
                                r_dret <= S_SQ; r_state <= S_MDIV;
                            end
                        end else begin
                            r_state <= r_dret;
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                        if (rem_sh >= r_den) begin
                            r_rem <= rem_sh - r_den; r_q <= {r_q[15:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh; r_q <= {r_q[15:0], 1'b0};
                        end
                    end
                end
                S_SQ, S_GSQ: begin
                    r_acc <= 67'(mul_p);
                    r_state <= (r_state == S_SQ) ? S_CUBE : S_GCUBE;
                end
                S_CUBE: begin
                    r_mag <= 17'(mul_p[67:16]);
                    r_state <= S_TOL;
                end
                S_TOL: begin
                    r_tolv <= (mul_p[49:16] == '0) ? 34'sd1 : 34'(mul_p[49:16]);
                    r_state <= S_GDIV;
                end
                S_GDIV: begin
                    if (gnum[33] || gnum == '0) begin
                        r_gate <= '0; r_state <= S_DR1;
                    end else begin
                        r_rem <= 50'(gnum); r_den <= 50'(r_tolv);
                        r_cnt <= '0; r_q <= '0;
                        r_dret <= S_GSQ; r_state <= S_MDIV;
                    end
                end
                S_GCUBE: begin r_gate <= 17'(mul_p[67:16]); r_state <= S_DR1; end
                S_DR1: begin r_acc <= 67'(mul_p); r_state <= S_DR2; end
                S_DR2: begin r_acc <= 67'(mul_p); r_state <= S_OUT; end
                S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
                    r_out <= {5'd0, r_gate, r_mag, drv_sat};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tdata  = r_out;

    `ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n, (r_state != S_IDLE) |-> !s_axis_tready)
    `ASSERT_IMPL(a_mag_range, i_clk, i_rst_n, r_mag <= 17'(gdv_pkg::OneQ16))
    `ASSERT_IMPL(a_gate_range, i_clk, i_rst_n, r_gate <= 17'(gdv_pkg::OneQ16))
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule
